>>> hdl/acwa_pkg.sv
// shared types and constants of the arp cache with aging
// no dependencies; imported by the top level and the entry compare unit
package acwa_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int IP_W        = 32;
    localparam int MAC_W       = 48;
    localparam int STAMP_W     = 32;
    localparam int AGE_W       = 16;

    localparam logic [AGE_W-1:0] MAX_AGE_RESET = 16'd300;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    typedef struct packed {
        logic [IP_W-1:0]    ip;
        logic [MAC_W-1:0]   mac;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    typedef struct packed {
        logic hit;
        logic stale;
        logic older;
    } t_cmp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EMPTY,
        S_RD,
        S_CMP,
        S_SH_RD,
        S_SH_WR,
        S_DONE
    } t_state;

endpackage

>>> hdl/acwa_entry_unit.sv
// shared compare unit: key match, age check and oldest-stamp compare on one entry
// depends on acwa_pkg
module acwa_entry_unit
    import acwa_pkg::*;
(
    input  t_entry             i_entry,
    input  logic [IP_W-1:0]    i_key,
    input  logic [STAMP_W-1:0] i_now,
    input  logic [AGE_W-1:0]   i_max_age,
    input  logic [STAMP_W-1:0] i_best_stamp,
    output t_cmp               o_cmp
);

    logic [STAMP_W-1:0] age;

    // age wraps modulo 2^32
    assign age         = i_now - i_entry.stamp;
    assign o_cmp.hit   = (i_entry.ip == i_key);
    assign o_cmp.stale = (age >= STAMP_W'(i_max_age));
    assign o_cmp.older = (i_entry.stamp < i_best_stamp);

endmodule

>>> hdl/arp_cache_with_aging_top.sv
// sequence: each entry is read (S_RD) and compared (S_CMP), or after a stale hit read (S_SH_RD)
//   and moved down (S_SH_WR), then the result is handed over (S_DONE); no entry is visited twice
// items: one at a time; the next item is taken once the result sits in the output register,
//   which holds it until the sink takes it
// reset: synchronous active low; clears the entry count, the sequencer and the
//   output valid, and sets the age limit to 300; the entry memory is not cleared
module arp_cache_with_aging_top
    import acwa_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input item channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_operation,
    input  logic [IP_W-1:0]    i_ip_address,
    input  logic [MAC_W-1:0]   i_mac_address,
    input  logic [STAMP_W-1:0] i_now_seconds,
    // result item channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_found,
    output logic [MAC_W-1:0]   o_mac_result,
    // age limit register
    input  logic               i_cfg_we,
    input  logic [AGE_W-1:0]   i_cfg_wdata
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(ENTRIES);

    // entry memory: one write port, one registered read port at r_idx
    t_entry r_mem [ENTRIES];
    t_entry r_rd_data;

    t_state             r_state, n_state;
    logic [AGE_W-1:0]   r_max_age;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic               r_op, n_op;
    logic [IP_W-1:0]    r_ip, n_ip;
    logic [MAC_W-1:0]   r_mac, n_mac;
    logic [STAMP_W-1:0] r_now, n_now;
    logic [IDX_W-1:0]   r_old_idx, n_old_idx;
    logic [STAMP_W-1:0] r_old_time, n_old_time;
    logic               r_res_found, n_res_found;
    logic [MAC_W-1:0]   r_res_mac, n_res_mac;
    logic               r_out_valid, n_out_valid;
    logic               r_found, n_found;
    logic [MAC_W-1:0]   r_mac_out, n_mac_out;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    t_entry             wr_data;
    t_cmp               cmp;
    logic [CNT_W-1:0]   idx_nxt;
    logic               last;
    logic               take_old;

    // one compare unit, reused for every entry the scan visits
    acwa_entry_unit u_unit (
        .i_entry      (r_rd_data),
        .i_key        (r_ip),
        .i_now        (r_now),
        .i_max_age    (r_max_age),
        .i_best_stamp (r_old_time),
        .o_cmp        (cmp)
    );

    assign idx_nxt  = CNT_W'(r_idx) + CNT_W'(1);
    assign last     = (idx_nxt == r_count);
    // lowest index wins a tie, so only a strictly older stamp replaces the pick
    assign take_old = (r_idx == '0) || cmp.older;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_max_age   <= MAX_AGE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_max_age <= i_cfg_wdata;
            end
        end
    end

    // payload and scan registers
    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_op        <= n_op;
        r_ip        <= n_ip;
        r_mac       <= n_mac;
        r_now       <= n_now;
        r_old_idx   <= n_old_idx;
        r_old_time  <= n_old_time;
        r_res_found <= n_res_found;
        r_res_mac   <= n_res_mac;
        r_found     <= n_found;
        r_mac_out   <= n_mac_out;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_op        = r_op;
        n_ip        = r_ip;
        n_mac       = r_mac;
        n_now       = r_now;
        n_old_idx   = r_old_idx;
        n_old_time  = r_old_time;
        n_res_found = r_res_found;
        n_res_mac   = r_res_mac;
        n_found     = r_found;
        n_mac_out   = r_mac_out;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready  = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = r_idx;
        wr_data     = '{ip: r_ip, mac: r_mac, stamp: r_now};

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_op        = i_operation;
                    n_ip        = i_ip_address;
                    n_mac       = i_mac_address;
                    n_now       = i_now_seconds;
                    n_idx       = '0;
                    n_res_found = 1'b0;
                    n_res_mac   = '0;
                    n_state     = (r_count == '0) ? S_EMPTY : S_RD;
                end
            end
            S_EMPTY: begin
                // empty cache: lookup misses, insert lands in entry zero
                if (r_op == OP_INSERT) begin
                    wr_en   = 1'b1;
                    wr_addr = '0;
                    n_count = CNT_W'(1);
                end
                n_state = S_DONE;
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (cmp.hit) begin
                    if (r_op == OP_INSERT) begin
                        // refresh the existing mapping in place
                        wr_en   = 1'b1;
                        n_state = S_DONE;
                    end else if (!cmp.stale) begin
                        n_res_found = 1'b1;
                        n_res_mac   = r_rd_data.mac;
                        n_state     = S_DONE;
                    end else if (last) begin
                        n_count = r_count - CNT_W'(1);
                        n_state = S_DONE;
                    end else begin
                        // stale hit: close the gap by moving later entries down
                        n_idx   = IDX_W'(idx_nxt);
                        n_state = S_SH_RD;
                    end
                end else begin
                    if (take_old) begin
                        n_old_idx  = r_idx;
                        n_old_time = r_rd_data.stamp;
                    end
                    if (last) begin
                        if (r_op == OP_INSERT) begin
                            wr_en = 1'b1;
                            if (r_count != FULL) begin
                                wr_addr = IDX_W'(r_count);
                                n_count = r_count + CNT_W'(1);
                            end else begin
                                // full: evict the oldest stamp
                                wr_addr = take_old ? r_idx : r_old_idx;
                            end
                        end
                        n_state = S_DONE;
                    end else begin
                        n_idx   = IDX_W'(idx_nxt);
                        n_state = S_RD;
                    end
                end
            end
            S_SH_RD: begin
                n_state = S_SH_WR;
            end
            S_SH_WR: begin
                wr_en   = 1'b1;
                wr_addr = r_idx - IDX_W'(1);
                wr_data = r_rd_data;
                if (last) begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_DONE;
                end else begin
                    n_idx   = IDX_W'(idx_nxt);
                    n_state = S_SH_RD;
                end
            end
            S_DONE: begin
                // hand the result over once the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_found     = r_res_found;
                    n_mac_out   = r_res_mac;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid  = r_out_valid;
    assign o_found      = r_found;
    assign o_mac_result = r_mac_out;

endmodule

>>> hdl/acwa_checker.sv
// port-level checks of the arp cache with aging, bound to the top level
// no package dependency; sees the top level ports only
module acwa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_found,
    input logic [47:0] o_mac_result
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_found) && $stable(o_mac_result))
        else $error("result item changed while stalled");

    // a miss or an insert reports a zero mac
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_mac_result == 48'd0)
        else $error("nonzero mac on a miss");

    // the block is busy in the cycle after taking an item
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready right after an accepted item");

    // reset leaves no result pending
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind arp_cache_with_aging_top acwa_checker u_acwa_checker (.*);
